### sv/dcc_packet_encoder_defines.svh
// ----------------------------------------------------------------------------
// DCC packet encoder assertion macros
// Shared assertion helpers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef DCC_PACKET_ENCODER_DEFINES_SVH
`define DCC_PACKET_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define DCC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define DCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define DCC_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define DCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### sv/dcc_pkg.sv
// ----------------------------------------------------------------------------
// dcc_pkg
// Types, codes and constants shared by the DCC packet encoder modules.
// ----------------------------------------------------------------------------
package dcc_pkg;

   // packet sizing
   localparam int MAX_PACKET_BYTES = 6;
   localparam int DATA_BYTES_MAX   = 5;
   localparam int BYTE_IDX_WIDTH   = $clog2(DATA_BYTES_MAX + 1);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // command codes
   localparam logic [2:0] FUNC_THROTTLE = 3'd0;
   localparam logic [2:0] FUNC_FN_ONE   = 3'd1;
   localparam logic [2:0] FUNC_FN_TWO   = 3'd2;
   localparam logic [2:0] FUNC_ACCESS   = 3'd3;
   localparam logic [2:0] FUNC_CV_BYTE  = 3'd4;
   localparam logic [2:0] FUNC_CV_BIT   = 3'd5;

   // packet kinds
   localparam logic [2:0] KIND_THROTTLE = 3'd0;
   localparam logic [2:0] KIND_FUNCTION = 3'd1;
   localparam logic [2:0] KIND_ACCESS   = 3'd2;
   localparam logic [2:0] KIND_CV_BYTE  = 3'd3;
   localparam logic [2:0] KIND_CV_BIT   = 3'd4;

   // repeat counts
   localparam logic [2:0] REPEAT_THROTTLE = 3'd0;
   localparam logic [2:0] REPEAT_DEFAULT  = 3'd3;
   localparam logic [2:0] REPEAT_CV_BIT   = 3'd4;

   // byte constants
   localparam logic [13:0] SHORT_ADDR_MAX = 14'd127;
   localparam logic [7:0]  LONG_ADDR_MARK = 8'hC0;
   localparam logic [7:0]  SPEED_128_INST = 8'h3F;
   localparam logic [7:0]  FN1_MASK       = 8'hBF;
   localparam logic [7:0]  FN1_SET        = 8'h80;
   localparam logic [7:0]  FN2_SET        = 8'hDE;
   localparam logic [7:0]  FN2_MASK       = 8'hDF;
   localparam logic [7:0]  ACC_XOR        = 8'hF8;
   localparam logic [7:0]  ACC_BASE       = 8'h80;
   localparam logic [7:0]  CV_BYTE_INST   = 8'hEC;
   localparam logic [7:0]  CV_BIT_INST    = 8'hE8;
   localparam logic [7:0]  CV_BIT_DATA    = 8'hF0;
   localparam logic [6:0]  SPEED_MAX      = 7'd126;

   typedef struct packed {
      logic [2:0]  func;
      logic [13:0] loco_address;
      logic [6:0]  speed;
      logic        direction;
      logic [7:0]  function_byte1;
      logic [7:0]  function_byte2;
      logic [10:0] cv_number;
      logic [7:0]  cv_value;
      logic [2:0]  bit_number;
      logic [1:0]  accessory_output;
      logic        activate;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  packet_byte;
      logic        last;
      logic [2:0]  repeat_count;
      logic [2:0]  packet_kind;
      logic [15:0] transaction_id;
      logic [15:0] railcom_address;
   } rsp_payload_type;

   typedef logic [DATA_BYTES_MAX-1:0][7:0] dcc_bytes_type;

   // one built packet waiting for serialization
   typedef struct packed {
      dcc_bytes_type             data;
      logic [BYTE_IDX_WIDTH-1:0] byte_count;
      logic [2:0]                repeat_count;
      logic [2:0]                packet_kind;
      logic [15:0]               transaction_id;
      logic [15:0]               railcom_address;
   } dcc_desc_type;

   // queue handshake as seen by the back end
   typedef struct packed {
      logic         valid;
      dcc_desc_type head;
   } dcc_qhead_type;

endpackage

### sv/dcc_front.sv
// ----------------------------------------------------------------------------
// dcc_front
// Decodes one command beat into packet data bytes and header fields.
// ----------------------------------------------------------------------------
module dcc_front
   import dcc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   input  logic            q_full,
   output logic            q_push,
   output dcc_desc_type    q_desc
);

   logic [15:0]               seq_ff;
   logic [15:0]               seq_in;
   logic                      accept;
   logic                      func_ok;
   logic                      use_addr;
   logic                      addr_long;
   logic [7:0]                addr_hi;
   logic [7:0]                addr_lo;
   logic [9:0]                cv_index;
   logic [6:0]                speed_sat;
   logic [2:0][7:0]           cmd;
   logic [BYTE_IDX_WIDTH-1:0] cmd_count;
   logic [BYTE_IDX_WIDTH-1:0] total;
   logic [2:0]                kind;
   logic [2:0]                repeats;
   dcc_bytes_type             data;
   logic [15:0]               rc;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   // address bytes and common operands
   always_comb begin
      addr_long = req_payload.loco_address > SHORT_ADDR_MAX;
      addr_hi   = {2'b00, req_payload.loco_address[13:8]} | LONG_ADDR_MARK;
      addr_lo   = req_payload.loco_address[7:0];
      cv_index  = req_payload.cv_number[9:0] - 10'd1;
      speed_sat = (req_payload.speed > SPEED_MAX) ? SPEED_MAX : req_payload.speed;
   end

   // instruction bytes per command
   always_comb begin
      cmd       = '0;
      cmd_count = '0;
      use_addr  = 1'b1;
      func_ok   = 1'b1;
      kind      = KIND_FUNCTION;
      repeats   = REPEAT_DEFAULT;
      unique case (req_payload.func)
         FUNC_THROTTLE: begin
            cmd[0]    = SPEED_128_INST;
            cmd[1]    = {req_payload.direction,
                         speed_sat + {6'd0, (speed_sat != 7'd0)}};
            cmd_count = BYTE_IDX_WIDTH'(2);
            kind      = KIND_THROTTLE;
            repeats   = REPEAT_THROTTLE;
         end
         FUNC_FN_ONE: begin
            cmd[0]    = (req_payload.function_byte1 | FN1_SET) & FN1_MASK;
            cmd_count = BYTE_IDX_WIDTH'(1);
         end
         FUNC_FN_TWO: begin
            cmd[0]    = (req_payload.function_byte1 | FN2_SET) & FN2_MASK;
            cmd[1]    = req_payload.function_byte2;
            cmd_count = BYTE_IDX_WIDTH'(2);
         end
         FUNC_ACCESS: begin
            cmd[0]    = {2'b00, req_payload.loco_address[5:0]} | ACC_BASE;
            cmd[1]    = {1'b0, req_payload.loco_address[8:6], 1'b0,
                         req_payload.accessory_output, req_payload.activate} ^ ACC_XOR;
            cmd_count = BYTE_IDX_WIDTH'(2);
            use_addr  = 1'b0;
            kind      = KIND_ACCESS;
         end
         FUNC_CV_BYTE: begin
            cmd[0]    = CV_BYTE_INST + {6'd0, cv_index[9:8]};
            cmd[1]    = cv_index[7:0];
            cmd[2]    = req_payload.cv_value;
            cmd_count = BYTE_IDX_WIDTH'(3);
            kind      = KIND_CV_BYTE;
         end
         FUNC_CV_BIT: begin
            cmd[0]    = CV_BIT_INST + {6'd0, cv_index[9:8]};
            cmd[1]    = cv_index[7:0];
            cmd[2]    = CV_BIT_DATA | {4'd0, req_payload.cv_value[0],
                                       req_payload.bit_number};
            cmd_count = BYTE_IDX_WIDTH'(3);
            kind      = KIND_CV_BIT;
            repeats   = REPEAT_CV_BIT;
         end
         default: begin
            func_ok = 1'b0;
         end
      endcase
   end

   // assemble address and instruction bytes
   always_comb begin
      data = '0;
      if (!use_addr) begin
         for (int i = 0; i < 3; i++) data[i] = cmd[i];
         total = cmd_count;
         rc    = {cmd[0], cmd[1]};
      end else if (addr_long) begin
         data[0] = addr_hi;
         data[1] = addr_lo;
         for (int i = 0; i < 3; i++) data[i+2] = cmd[i];
         total = cmd_count + BYTE_IDX_WIDTH'(2);
         rc    = {addr_hi, addr_lo};
      end else begin
         data[0] = addr_lo;
         for (int i = 0; i < 3; i++) data[i+1] = cmd[i];
         total = cmd_count + BYTE_IDX_WIDTH'(1);
         rc    = {8'd0, addr_lo};
      end
   end

   // transaction number, one per valid command
   assign seq_in = seq_ff + 16'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= '0;
      end else if (accept && func_ok) begin
         seq_ff <= seq_in;
      end
   end

   assign q_push = accept && func_ok && (int'(total) < MAX_PACKET_BYTES);

   always_comb begin
      q_desc.data            = data;
      q_desc.byte_count      = total;
      q_desc.repeat_count    = repeats;
      q_desc.packet_kind     = kind;
      q_desc.transaction_id  = seq_in;
      q_desc.railcom_address = rc;
   end

endmodule

### sv/dcc_queue.sv
// ----------------------------------------------------------------------------
// dcc_queue
// Short packet queue that decouples command decode from byte output.
// ----------------------------------------------------------------------------
module dcc_queue
   import dcc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  dcc_desc_type  push_desc,
   output logic          full,
   input  logic          pop,
   output dcc_qhead_type qhead
);

   dcc_desc_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff;
   logic [QCNT_WIDTH-1:0] count_ff;
   logic [QCNT_WIDTH-1:0] count_in;

   assign full       = count_ff == QCNT_WIDTH'(QUEUE_DEPTH);
   assign qhead.valid = count_ff != '0;
   assign qhead.head  = entry_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + QCNT_WIDTH'(1);
      if (pop && !push) count_in = count_ff - QCNT_WIDTH'(1);
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0
                                : wr_ptr_ff + QPTR_WIDTH'(1);
         if (pop)  rd_ptr_ff <= (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0
                                : rd_ptr_ff + QPTR_WIDTH'(1);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_desc;
   end

endmodule

### sv/dcc_back.sv
// ----------------------------------------------------------------------------
// dcc_back
// Serializes a queued packet one byte per beat and appends the checksum.
// ----------------------------------------------------------------------------
module dcc_back
   import dcc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  dcc_qhead_type   qhead,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic [BYTE_IDX_WIDTH-1:0] idx_ff;
   logic [BYTE_IDX_WIDTH-1:0] idx_in;
   logic [7:0]                chk_ff;
   logic [7:0]                chk_in;
   logic                      rsp_valid_ff;
   rsp_payload_type           rsp_ff;
   rsp_payload_type           rsp_in;
   logic                      advance;
   logic                      emit;
   logic                      at_end;
   logic [7:0]                data_sel;

   // output register frees when empty or taken
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign emit    = advance && qhead.valid;
   assign at_end  = idx_ff == qhead.head.byte_count;
   assign pop     = emit && at_end;

   // byte select and running checksum
   always_comb begin
      data_sel = '0;
      if (32'(idx_ff) < DATA_BYTES_MAX) data_sel = qhead.head.data[idx_ff];
      rsp_in.packet_byte     = at_end ? chk_ff : data_sel;
      rsp_in.last            = at_end;
      rsp_in.repeat_count    = qhead.head.repeat_count;
      rsp_in.packet_kind     = qhead.head.packet_kind;
      rsp_in.transaction_id  = qhead.head.transaction_id;
      rsp_in.railcom_address = qhead.head.railcom_address;
      idx_in = at_end ? '0 : idx_ff + BYTE_IDX_WIDTH'(1);
      chk_in = at_end ? '0 : chk_ff ^ data_sel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         chk_ff       <= '0;
      end else if (advance) begin
         rsp_valid_ff <= qhead.valid;
         if (qhead.valid) begin
            idx_ff <= idx_in;
            chk_ff <= chk_in;
         end
      end
   end

   // output beat
   always_ff @(posedge clock) begin
      if (emit) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### sv/dcc_packet_encoder.sv
// ----------------------------------------------------------------------------
// dcc_packet_encoder
// Builds DCC packet bytes from commands and streams them with a checksum.
// ----------------------------------------------------------------------------
// A command beat is decoded in the cycle it is taken and its packet is queued
// in a two-entry queue; a new command can be taken every cycle while the
// queue has room. The output side sends one byte per cycle from its output
// register while rsp_stall is low, so a packet with n data bytes (2 to 5)
// leaves as n + 1 bytes including its checksum byte; the output side thus
// sets the sustained rate. Unused command codes are taken and produce nothing.
`include "dcc_packet_encoder_defines.svh"

module dcc_packet_encoder
   import dcc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic          q_push;
   logic          q_full;
   logic          q_pop;
   dcc_desc_type  q_desc;
   dcc_qhead_type qhead;

   // command decode
   dcc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_desc      (q_desc)
   );

   // packet queue
   dcc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_desc),
      .full      (q_full),
      .pop       (q_pop),
      .qhead     (qhead)
   );

   // byte serializer
   dcc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .qhead       (qhead),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // checks
   `DCC_ASSERT_NOW(a_no_push_full, clock, reset, q_push, !q_full, "push into full queue")
   `DCC_ASSERT_NOW(a_pop_valid, clock, reset, q_pop, qhead.valid, "pop from empty queue")
   `DCC_ASSERT_NEXT(a_tid_in_packet, clock, reset, rsp_valid && !rsp_stall && !rsp_payload.last, rsp_valid == 1'b0 || rsp_payload.transaction_id == $past(rsp_payload.transaction_id), "transaction id changed inside packet")

endmodule
